// ===== hw/rtl/tlwbc_pkg.sv =====
// Package for the text line, word and byte counter.
// Item kind codes, character codes, default sizes and the byte class struct.
// No dependencies.
package tlwbc_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result field width at the ports.
  localparam int OUT_BITS = 48;

  // Defaults for the top-level parameters.
  localparam int COUNT_BITS_DEF = 48;
  localparam int TAB_WIDTH_DEF  = 8;

  // What one data byte does to the counters.
  typedef struct packed {
    logic is_lf;       // counts a line
    logic ends_line;   // LF, CR, FF
    logic is_tab;      // column to next tab stop
    logic col_inc;     // printable incl. space: column + 1
    logic starts_word; // printable non-space
    logic ends_word;   // whitespace incl. VT
  } byte_class_t;

endpackage

// ===== hw/rtl/text_line_word_byte_counter.sv =====
// Top level of the text line, word and byte counter (wc style).
// Depends on tlwbc_pkg and tlwbc_char_class.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_ready  | kind, data_byte
//  out     | out_valid/out_ready| line_total, word_total, byte_total,
//          |                    | longest_line, is_total
//
// One item per cycle sustained unless an end-of-file or totals item waits on a
// held result. An item is captured in an input register and applied to the
// counters from there; an end-of-file or totals item loads the result register as it is applied.
// rst clears all counters, the totals and both valid flags.
// A stalled result only holds back an item that itself makes a result;
// data bytes keep flowing past a full result register.
module text_line_word_byte_counter #(
  parameter int COUNT_BITS = tlwbc_pkg::COUNT_BITS_DEF, // counter width, 16..64
  parameter int TAB_WIDTH  = tlwbc_pkg::TAB_WIDTH_DEF   // tab stop spacing, 1..64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlwbc_pkg::OUT_BITS-1:0] line_total,
  output logic [tlwbc_pkg::OUT_BITS-1:0] word_total,
  output logic [tlwbc_pkg::OUT_BITS-1:0] byte_total,
  output logic [tlwbc_pkg::OUT_BITS-1:0] longest_line,
  output logic                          is_total
);
  import tlwbc_pkg::*;

  localparam int CB = COUNT_BITS;
  // Column position within the current tab stop, kept alongside the column
  // so a tab needs no modulo.
  localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam logic [CB-1:0] CMASK = {CB{1'b1}};
  localparam logic [PW-1:0] SAT_PHASE = PW'(CMASK % TAB_WIDTH);
  localparam logic [PW-1:0] LAST_PHASE = PW'(TAB_WIDTH - 1);
  localparam logic [CB:0]   TAB_STEP = (CB + 1)'(TAB_WIDTH);

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] a);
    sat_inc = (a == CMASK) ? a : a + 1'b1;
  endfunction

  function automatic logic [CB-1:0] sat_sum(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_sum = s[CB] ? CMASK : s[CB-1:0];
  endfunction

  // ---------------- input register ----------------
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_byte;
  logic       s1_makes_result;
  logic       s1_go;

  // ---------------- per-file and running state ----------------
  logic [CB-1:0] file_lines, file_words, file_bytes, file_longest, column;
  logic [PW-1:0] phase;
  logic          inside_word;
  logic [CB-1:0] sum_lines, sum_words, sum_bytes, overall_longest;

  logic [CB-1:0] file_lines_next, file_words_next, file_bytes_next, file_longest_next;
  logic [CB-1:0] column_next;
  logic [PW-1:0] phase_next;
  logic          inside_word_next;
  logic [CB-1:0] sum_lines_next, sum_words_next, sum_bytes_next, overall_longest_next;

  // ---------------- result register ----------------
  logic [CB-1:0] res_lines, res_words, res_bytes, res_longest;
  logic          res_is_total;

  tlwbc_pkg::byte_class_t cls;

  tlwbc_char_class u_class (
    .data_byte (s1_byte),
    .cls       (cls)
  );

  assign s1_makes_result = s1_kind inside {KIND_EOF, KIND_TOTAL};
  // Stage 1 retires unless it holds a result and the result slot is blocked.
  assign s1_go    = s1_valid && (!s1_makes_result || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind <= kind;
      s1_byte <= data_byte;
    end
  end

  // Closed-out values for an end-of-file item.
  logic [CB-1:0] eof_words, eof_longest;
  assign eof_words   = inside_word ? sat_inc(file_words) : file_words;
  assign eof_longest = (column > file_longest) ? column : file_longest;

  // Tab advance.
  logic [CB:0] tab_sum;
  assign tab_sum = {1'b0, column} + (TAB_STEP - (CB + 1)'(phase));

  always_comb begin
    file_lines_next      = file_lines;
    file_words_next      = file_words;
    file_bytes_next      = file_bytes;
    file_longest_next    = file_longest;
    column_next          = column;
    phase_next           = phase;
    inside_word_next     = inside_word;
    sum_lines_next       = sum_lines;
    sum_words_next       = sum_words;
    sum_bytes_next       = sum_bytes;
    overall_longest_next = overall_longest;

    case (s1_kind)
      KIND_DATA: begin
        file_bytes_next = sat_inc(file_bytes);
        if (cls.is_lf) begin
          file_lines_next = sat_inc(file_lines);
        end
        if (cls.ends_line) begin
          file_longest_next = eof_longest;
          column_next       = '0;
          phase_next        = '0;
        end else if (cls.is_tab) begin
          if (tab_sum[CB]) begin
            column_next = CMASK;
            phase_next  = SAT_PHASE;
          end else begin
            column_next = tab_sum[CB-1:0];
            phase_next  = '0;
          end
        end else if (cls.col_inc && column != CMASK) begin
          column_next = column + 1'b1;
          phase_next  = (phase == LAST_PHASE) ? '0 : phase + 1'b1;
        end
        if (cls.ends_word) begin
          file_words_next  = eof_words;
          inside_word_next = 1'b0;
        end else if (cls.starts_word) begin
          inside_word_next = 1'b1;
        end
      end
      KIND_EOF: begin
        sum_lines_next       = sat_sum(sum_lines, file_lines);
        sum_words_next       = sat_sum(sum_words, eof_words);
        sum_bytes_next       = sat_sum(sum_bytes, file_bytes);
        overall_longest_next = (eof_longest > overall_longest) ? eof_longest
                                                               : overall_longest;
        file_lines_next   = '0;
        file_words_next   = '0;
        file_bytes_next   = '0;
        file_longest_next = '0;
        column_next       = '0;
        phase_next        = '0;
        inside_word_next  = 1'b0;
      end
      default: begin
        // totals report reads only; the unused code is dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_lines      <= '0;
      file_words      <= '0;
      file_bytes      <= '0;
      file_longest    <= '0;
      column          <= '0;
      phase           <= '0;
      inside_word     <= 1'b0;
      sum_lines       <= '0;
      sum_words       <= '0;
      sum_bytes       <= '0;
      overall_longest <= '0;
    end else if (s1_go) begin
      file_lines      <= file_lines_next;
      file_words      <= file_words_next;
      file_bytes      <= file_bytes_next;
      file_longest    <= file_longest_next;
      column          <= column_next;
      phase           <= phase_next;
      inside_word     <= inside_word_next;
      sum_lines       <= sum_lines_next;
      sum_words       <= sum_words_next;
      sum_bytes       <= sum_bytes_next;
      overall_longest <= overall_longest_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_makes_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_makes_result) begin
      if (s1_kind == KIND_EOF) begin
        res_lines    <= file_lines;
        res_words    <= eof_words;
        res_bytes    <= file_bytes;
        res_longest  <= eof_longest;
        res_is_total <= 1'b0;
      end else begin
        res_lines    <= sum_lines;
        res_words    <= sum_words;
        res_bytes    <= sum_bytes;
        res_longest  <= overall_longest;
        res_is_total <= 1'b1;
      end
    end
  end

  assign is_total = res_is_total;

  // Fit the counters to the fixed port width.
  generate
    if (CB >= OUT_BITS) begin : g_trunc
      assign line_total   = res_lines[OUT_BITS-1:0];
      assign word_total   = res_words[OUT_BITS-1:0];
      assign byte_total   = res_bytes[OUT_BITS-1:0];
      assign longest_line = res_longest[OUT_BITS-1:0];
    end else begin : g_ext
      assign line_total   = {{(OUT_BITS - CB){1'b0}}, res_lines};
      assign word_total   = {{(OUT_BITS - CB){1'b0}}, res_words};
      assign byte_total   = {{(OUT_BITS - CB){1'b0}}, res_bytes};
      assign longest_line = {{(OUT_BITS - CB){1'b0}}, res_longest};
    end
  endgenerate

endmodule

// ===== hw/rtl/tlwbc_char_class.sv =====
// Byte classifier for the text line, word and byte counter.
// Depends on tlwbc_pkg for the character codes and byte_class_t.
module tlwbc_char_class (
  input  logic [7:0]             data_byte,
  output tlwbc_pkg::byte_class_t cls
);
  import tlwbc_pkg::*;

  always_comb begin
    cls             = '0;
    cls.is_lf       = (data_byte == CH_LF);
    cls.ends_line   = data_byte inside {CH_LF, CH_CR, CH_FF};
    cls.is_tab      = (data_byte == CH_TAB);
    cls.col_inc     = data_byte inside {[CH_SPACE:CH_TILDE]};
    cls.starts_word = data_byte inside {[CH_BANG:CH_TILDE]};
    cls.ends_word   = cls.ends_line || cls.is_tab || (data_byte == CH_VT)
                      || (data_byte == CH_SPACE);
  end

endmodule

// ===== hw/rtl/tlwbc_checker.sv =====
// Port-level checks for the text line, word and byte counter, and its bind.
// Depends on tlwbc_pkg and text_line_word_byte_counter.
module tlwbc_checker #(
  parameter int COUNT_BITS = tlwbc_pkg::COUNT_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     kind,
  input logic [7:0]                     data_byte,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tlwbc_pkg::OUT_BITS-1:0] line_total,
  input logic [tlwbc_pkg::OUT_BITS-1:0] word_total,
  input logic [tlwbc_pkg::OUT_BITS-1:0] byte_total,
  input logic [tlwbc_pkg::OUT_BITS-1:0] longest_line,
  input logic                           is_total
);
  import tlwbc_pkg::*;

  // A waiting input item keeps valid and its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(data_byte))
    else $error("input item changed while waiting");

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_total) && $stable(word_total)
      && $stable(byte_total) && $stable(longest_line) && $stable(is_total))
    else $error("result changed while stalled");

  // Input backpressure only comes from a blocked result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result slot");

  // Every word and every newline takes at least one byte.
  a_word_le_bytes: assert property (@(posedge clk) disable iff (rst)
    (COUNT_BITS <= OUT_BITS) && out_valid |-> word_total <= byte_total)
    else $error("more words than bytes");

  a_line_le_bytes: assert property (@(posedge clk) disable iff (rst)
    (COUNT_BITS <= OUT_BITS) && out_valid |-> line_total <= byte_total)
    else $error("more lines than bytes");

endmodule

bind text_line_word_byte_counter tlwbc_checker #(.COUNT_BITS(COUNT_BITS)) u_tlwbc_checker (.*);

// ===== verif/tb_text_line_word_byte_counter.sv =====
// Testbench for text_line_word_byte_counter: directed and random byte streams, with
// random gaps on the input side and random stalls on the result side.
// Depends on tlwbc_pkg and the counter RTL.
module tb_text_line_word_byte_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import tlwbc_pkg::*;

  // Kind value the block has no use for; it must be dropped without a trace.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int TAB_STOP   = TAB_WIDTH_DEF;
  localparam bit [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  localparam int TARGET_ITEMS = 1725;   // directed + random, ignored kinds not counted
  localparam int DRAIN_CYCLES = 8;      // quiet time after the last report, to catch stray results
  localparam int CYCLE_LIMIT  = 400000;

  // One counter report as it shows up on the result port.
  typedef struct packed {
    logic [OUT_BITS-1:0] lines;
    logic [OUT_BITS-1:0] words;
    logic [OUT_BITS-1:0] chars;
    logic [OUT_BITS-1:0] widest;
    logic                is_total;
  } tally_t;

  // Scoreboard: keeps its own copy of the per-file and running counters, turns
  // every accepted item into the report it should cause, and checks results
  // against the oldest report still outstanding.
  class wc_count_board;
    bit [63:0] f_lines, f_words, f_bytes, f_widest, col;
    bit        in_word;
    bit [63:0] t_lines, t_words, t_bytes, t_widest;
    tally_t    pending_counts[$];
    int        n_errors = 0;

    function bit [63:0] bump(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[63:0];
    endfunction

    function void close_line();
      if (col > f_widest) f_widest = col;
      col = '0;
    endfunction

    function void close_word();
      if (in_word) begin
        in_word = 1'b0;
        f_words = bump(f_words, 64'd1);
      end
    endfunction

    function void note_item(logic [1:0] k, logic [7:0] ch);
      tally_t res;
      case (k)
        KIND_DATA: begin
          f_bytes = bump(f_bytes, 64'd1);
          case (ch)
            CH_LF: begin
              f_lines = bump(f_lines, 64'd1);
              close_line();
              close_word();
            end
            CH_CR, CH_FF: begin
              close_line();
              close_word();
            end
            CH_TAB: begin
              col = bump(col, TAB_STOP - (col % TAB_STOP));
              close_word();
            end
            CH_SPACE: begin
              col = bump(col, 64'd1);
              close_word();
            end
            CH_VT: close_word();
            default: begin
              // other control bytes and high bytes only count as bytes
              if (ch >= CH_BANG && ch <= CH_TILDE) begin
                col = bump(col, 64'd1);
                in_word = 1'b1;
              end
            end
          endcase
        end
        KIND_EOF: begin
          close_line();
          close_word();
          res = '{f_lines[OUT_BITS-1:0], f_words[OUT_BITS-1:0], f_bytes[OUT_BITS-1:0],
                  f_widest[OUT_BITS-1:0], 1'b0};
          pending_counts.push_back(res);
          t_lines = bump(t_lines, f_lines);
          t_words = bump(t_words, f_words);
          t_bytes = bump(t_bytes, f_bytes);
          if (f_widest > t_widest) t_widest = f_widest;
          f_lines = '0; f_words = '0; f_bytes = '0; f_widest = '0;
          col = '0; in_word = 1'b0;
        end
        KIND_TOTAL: begin
          res = '{t_lines[OUT_BITS-1:0], t_words[OUT_BITS-1:0], t_bytes[OUT_BITS-1:0],
                  t_widest[OUT_BITS-1:0], 1'b1};
          pending_counts.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_counts.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      n_errors++;
    endtask

    task cmp_field(string name, logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
      if (got !== want) report($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    task check_result(tally_t got);
      tally_t want;
      if (pending_counts.size() == 0) begin
        report("result arrived with no report outstanding");
        return;
      end
      want = pending_counts.pop_front();
      cmp_field("line_total", want.lines, got.lines);
      cmp_field("word_total", want.words, got.words);
      cmp_field("byte_total", want.chars, got.chars);
      cmp_field("longest_line", want.widest, got.widest);
      if (got.is_total !== want.is_total)
        report($sformatf("is_total: expected %0b, got %0b", want.is_total, got.is_total));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          kind;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_ready;
  logic [OUT_BITS-1:0] line_total;
  logic [OUT_BITS-1:0] word_total;
  logic [OUT_BITS-1:0] byte_total;
  logic [OUT_BITS-1:0] longest_line;
  logic                is_total;

  wc_count_board sb = new();

  int n_items   = 0;   // accepted items, ignored kind excluded
  int n_results = 0;
  int cycles    = 0;
  bit in_quiet  = 1'b0;   // while set, the input side sends back to back
  bit out_quiet = 1'b0;   // while set, the result side never stalls

  text_line_word_byte_counter #(
    .COUNT_BITS(COUNT_BITS),
    .TAB_WIDTH (TAB_STOP)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_total  (line_total),
    .word_total  (word_total),
    .byte_total  (byte_total),
    .longest_line(longest_line),
    .is_total    (is_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Present one item and hold it until accepted. Called at a rising edge; on
  // return we sit at the accepting edge, so the next call can either keep valid
  // up with a new payload or drop it for a gap, never both in one step.
  task automatic send_item(input logic [1:0] k, input logic [7:0] ch);
    int gap;
    if (n_items % 150 == 0) in_quiet = ($urandom_range(0, 2) == 0);
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= ch;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(k, ch);
    if (k != KIND_UNUSED) n_items++;
  endtask

  // Mostly text: printable runs, spaces and newlines, with a sprinkle of the
  // other separators and arbitrary bytes.
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(CH_BANG, CH_TILDE));
    else if (r < 70) return CH_SPACE;
    else if (r < 78) return CH_LF;
    else if (r < 84) return CH_TAB;
    else if (r < 87) return CH_CR;
    else if (r < 89) return CH_FF;
    else if (r < 91) return CH_VT;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Result side: every accepted result is checked, then a random stall is drawn
  // for the next one.
  initial begin : result_side
    int     hold;
    tally_t got;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got = '{line_total, word_total, byte_total, longest_line, is_total};
        sb.check_result(got);
        n_results++;
        if (n_results % 25 == 0) out_quiet = ($urandom_range(0, 2) == 0);
        hold = out_quiet ? 0 : $urandom_range(0, 5);
        if (hold > 0) out_ready <= 1'b0;
      end else if (out_ready !== 1'b1) begin
        if (hold > 0) hold--;
        if (hold == 0) out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int  pick;
    int  flen;
    bit  wide;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_DATA;
    data_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty file, totals of nothing, every byte class, tab stops
    // off and on a boundary, the ignored kind, and totals that must persist.
    send_item(KIND_EOF, 8'hFF);
    send_item(KIND_TOTAL, 8'h00);
    send_item(KIND_DATA, CH_BANG);
    send_item(KIND_DATA, CH_TILDE);
    send_item(KIND_DATA, CH_TAB);        // column 2 -> 8
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h7F);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h1F);
    send_item(KIND_DATA, CH_TAB);        // already on a stop: 8 -> 16
    send_item(KIND_DATA, 8'h78);
    send_item(KIND_DATA, CH_VT);         // closes the word, column unchanged
    send_item(KIND_DATA, CH_SPACE);
    send_item(KIND_DATA, 8'h79);
    send_item(KIND_DATA, CH_CR);
    send_item(KIND_DATA, 8'h7A);
    send_item(KIND_DATA, CH_FF);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_DATA, 8'h71);
    send_item(KIND_DATA, CH_LF);
    send_item(KIND_DATA, CH_TAB);
    send_item(KIND_EOF, 8'hAA);          // open line of width 8 closes here
    send_item(KIND_TOTAL, 8'h55);
    send_item(KIND_TOTAL, 8'hFF);

    // Random files: mostly short, some long, some single-line and full of tabs,
    // with stray totals and ignored items between and inside files.
    while (n_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      end else if (pick < 10) begin
        send_item(KIND_TOTAL, 8'($urandom_range(0, 255)));
      end else begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
        wide = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < flen; i++) begin
          if ($urandom_range(0, 49) == 0)
            send_item(($urandom_range(0, 1) == 1) ? KIND_TOTAL : KIND_UNUSED,
                      8'($urandom_range(0, 255)));
          if (wide)
            send_item(KIND_DATA, ($urandom_range(0, 3) == 0) ? CH_TAB
                                   : 8'($urandom_range(CH_SPACE, CH_TILDE)));
          else
            send_item(KIND_DATA, text_char());
        end
        send_item(KIND_EOF, 8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // Let every outstanding report come out, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
